@@ rtl/core/mwc_pkg.sv @@
// ----------------------------------------------------------------------------
// mwc_pkg
// Shared widths, codes and the multiplier digit table for the
// multiply-with-carry range generator.
// ----------------------------------------------------------------------------
package mwc_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ACC_W     = WORD_W + 2;
  localparam int unsigned IN_DATA_W = 136;

  // s_tdata field offsets
  localparam int unsigned BOUND_A_LSB   = 0;
  localparam int unsigned BOUND_B_LSB   = 32;
  localparam int unsigned INCL_BIT      = 64;
  localparam int unsigned SEED_LOW_LSB  = 65;
  localparam int unsigned SEED_HIGH_LSB = 97;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [WORD_W-1:0] MWC_MULT = 32'h6AC6_90C5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ACC_W-1:0]  acc_t;

  // multiple of the constant for one radix-4 digit of the multiplier
  function automatic acc_t mult_multiple(input logic [1:0] digit);
    acc_t m1;
    m1 = {2'b00, MWC_MULT};
    case (digit)
      2'd0:    mult_multiple = '0;
      2'd1:    mult_multiple = m1;
      2'd2:    mult_multiple = m1 << 1;
      default: mult_multiple = (m1 << 1) + m1;
    endcase
  endfunction

endpackage

@@ rtl/core/mwc_random_in_range.sv @@
// ----------------------------------------------------------------------------
// mwc_random_in_range
// Multiply-with-carry generator with a draw of a value inside a signed range.
// ----------------------------------------------------------------------------
// A load, or a draw that does not step the generator, goes from the input beat
//   through ST_DONE to the result; a draw that steps it first passes through
//   ST_MUL and ST_MOD. One beat at a time; the step is a radix-4 shift-add multiply
//   followed by a bit-serial restoring remainder
// reset: synchronous, clears the generator words and the output valid
module mwc_random_in_range
  import mwc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // bound_a[31:0], bound_b[63:32], inclusive[64], seed_low[96:65],
  // seed_high[128:97], zero fill
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tuser,   // kind
  input  logic                 s_tvalid,
  output logic                 s_tready,
  output logic [WORD_W-1:0]    m_tdata,   // value
  output logic                 m_tuser,   // advanced
  output logic                 m_tvalid,
  input  logic                 m_tready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [4:0] MUL_LAST = 5'd15;
  localparam logic [4:0] MOD_LAST = 5'd31;

  logic [1:0] state;
  logic [4:0] cnt;
  word_t      gen_low;
  word_t      gen_high;
  acc_t       phi;
  word_t      plo;
  word_t      rem;
  word_t      rng;
  word_t      lo_reg;
  logic       adv;

  word_t bound_a;
  word_t bound_b;
  logic  incl;
  word_t seed_low;
  word_t seed_high;
  logic  a_ge_b;
  word_t hi_b;
  word_t lo_b;
  word_t range_raw;
  logic  range_ok;
  acc_t  mul_sum;
  word_t rem_sh;
  logic  rem_fit;

  assign bound_a   = s_tdata[BOUND_A_LSB +: WORD_W];
  assign bound_b   = s_tdata[BOUND_B_LSB +: WORD_W];
  assign incl      = s_tdata[INCL_BIT];
  assign seed_low  = s_tdata[SEED_LOW_LSB +: WORD_W];
  assign seed_high = s_tdata[SEED_HIGH_LSB +: WORD_W];

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    a_ge_b    = ($signed(bound_a) >= $signed(bound_b));
    hi_b      = a_ge_b ? bound_a : bound_b;
    lo_b      = a_ge_b ? bound_b : bound_a;
    range_raw = hi_b - lo_b + {{(WORD_W-1){1'b0}}, incl};
    range_ok  = (range_raw != '0) && !range_raw[WORD_W-1];
    mul_sum   = phi + mult_multiple(plo[1:0]);
    rem_sh    = {rem[WORD_W-2:0], plo[WORD_W-1]};
    rem_fit   = (rem_sh >= rng);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      gen_low  <= '0;
      gen_high <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cnt <= '0;
            rem <= '0;
            adv <= 1'b0;
            rng <= range_raw;
            if (s_tuser == KIND_LOAD) begin
              gen_low  <= seed_low;
              gen_high <= seed_high;
              lo_reg   <= '0;
              state    <= ST_DONE;
            end else if (bound_a == bound_b) begin
              lo_reg <= bound_b;
              state  <= ST_DONE;
            end else if (!range_ok) begin
              lo_reg <= lo_b;
              state  <= ST_DONE;
            end else begin
              lo_reg <= lo_b;
              phi    <= {2'b00, gen_high};
              plo    <= gen_low;
              adv    <= 1'b1;
              state  <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          phi <= {2'b00, mul_sum[ACC_W-1:2]};
          plo <= {mul_sum[1:0], plo[WORD_W-1:2]};
          cnt <= cnt + 5'd1;
          if (cnt == MUL_LAST) begin
            gen_low  <= {mul_sum[1:0], plo[WORD_W-1:2]};
            gen_high <= mul_sum[ACC_W-1:2];
            cnt      <= '0;
            state    <= ST_MOD;
          end
        end
        ST_MOD: begin
          plo <= {plo[WORD_W-2:0], 1'b0};
          rem <= rem_fit ? (rem_sh - rng) : rem_sh;
          cnt <= cnt + 5'd1;
          if (cnt == MOD_LAST) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= rem + lo_reg;
            m_tuser  <= adv;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/mwc_checker.sv @@
// ----------------------------------------------------------------------------
// mwc_checker
// Port-level checks for the multiply-with-carry range generator.
// ----------------------------------------------------------------------------
module mwc_checker
  import mwc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tuser,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [WORD_W-1:0]    m_tdata,
  input logic                 m_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready
);

  // after reset the block is empty and ready for a beat
  a_reset_idle: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("not idle after reset");

  // one beat in flight at a time
  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while busy");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a load beat gives a result that is not marked as stepped
  a_load_flag: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_LOAD) && !m_tvalid |=> ##1
    m_tvalid && !m_tuser && (m_tdata == '0))
    else $error("load beat result wrong");

endmodule

bind mwc_random_in_range mwc_checker u_mwc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tuser  (s_tuser),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);

@@ verif/mwc_random_in_range_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mwc_random_in_range_tb
// Self-checking bench for the multiply-with-carry range generator. A short
// table of loads and draws covers the bound extremes, equal bounds, ranges
// that are empty or too wide, and masked and modulo reductions. Random loads
// and draws with varied spans follow under four handshake pressure phases.
// Each result beat is compared against the value that a table row gives, or
// else against a bit-accurate software copy of the generator state.
// ----------------------------------------------------------------------------
module mwc_random_in_range_tb;
  import mwc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned PHASE_ITEMS  = 300;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic  kind;
    word_t bound_a;
    word_t bound_b;
    logic  inclusive;
    word_t seed_low;
    word_t seed_high;
    logic  known;
    word_t known_value;
    logic  known_advanced;
  } stim_row_t;

  typedef struct packed {
    word_t value;
    logic  advanced;
  } draw_out_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic [IN_DATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = KIND_LOAD;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [WORD_W-1:0]    m_tdata;
  logic                 m_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;

  word_t       gen_lo = '0;
  word_t       gen_hi = '0;
  draw_out_t   pending_draws [$];
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  stim_row_t   directed_rows [0:22];

  mwc_random_in_range DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic draw_out_t mwc_draw(input stim_row_t row);
    logic [63:0] prod;
    word_t       lo;
    word_t       hi;
    word_t       span;
    draw_out_t   res;
    res = '0;
    if (row.kind == KIND_LOAD) begin
      gen_lo = row.seed_low;
      gen_hi = row.seed_high;
    end else if (row.bound_a == row.bound_b) begin
      res.value = row.bound_a;
    end else begin
      if ($signed(row.bound_a) >= $signed(row.bound_b)) begin
        hi = row.bound_a;
        lo = row.bound_b;
      end else begin
        hi = row.bound_b;
        lo = row.bound_a;
      end
      span = hi - lo + {31'b0, row.inclusive};
      if (span == 0 || span[WORD_W-1]) begin
        res.value = lo;
      end else begin
        prod   = {32'b0, gen_lo} * {32'b0, MWC_MULT} + {32'b0, gen_hi};
        gen_lo = prod[31:0];
        gen_hi = prod[63:32];
        if ((span & (span - 32'd1)) == 0) begin
          res.value = lo + (gen_lo & (span - 32'd1));
        end else begin
          res.value = lo + gen_lo % span;
        end
        res.advanced = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic send_item(input stim_row_t row);
    draw_out_t predicted;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= row.kind;
    s_tdata  <= {7'b0, row.seed_high, row.seed_low, row.inclusive, row.bound_b, row.bound_a};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = mwc_draw(row);
    if (row.known) begin
      pending_draws.push_back({row.known_value, row.known_advanced});
    end else begin
      pending_draws.push_back(predicted);
    end
  endtask

  // result side: check each beat, then pick the next ready level
  always @(posedge clk) begin
    draw_out_t want;
    cycle_count = cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_draws.size() == 0) begin
        fail_count = fail_count + 1;
        $display("%0t: unexpected beat, expected none, actual value %h advanced %b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = pending_draws.pop_front();
        if (m_tdata !== want.value || m_tuser !== want.advanced) begin
          fail_count = fail_count + 1;
          $display("%0t: mismatch, expected value %h advanced %b, actual value %h advanced %b",
                   $time, want.value, want.advanced, m_tdata, m_tuser);
        end
      end
    end
    m_tready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL mwc_random_in_range");
      $finish;
    end
  end

  initial begin
    stim_row_t row;
    int unsigned pick;
    // kind, bound_a, bound_b, inclusive, seed_low, seed_high, known, value, advanced
    directed_rows[0]  = '{KIND_DRAW, 32'd5, 32'd10, 1'b0, 32'd0, 32'd0, 1'b1, 32'd5, 1'b1};
    directed_rows[1]  = '{KIND_DRAW, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'd0, 32'd0,
                          1'b1, 32'hFFFFFFFF, 1'b0};
    directed_rows[2]  = '{KIND_DRAW, 32'h80000000, 32'h7FFFFFFF, 1'b0, 32'd0, 32'd0,
                          1'b1, 32'h80000000, 1'b0};
    directed_rows[3]  = '{KIND_DRAW, 32'h7FFFFFFF, 32'h80000000, 1'b1, 32'd0, 32'd0,
                          1'b1, 32'h80000000, 1'b0};
    directed_rows[4]  = '{KIND_DRAW, 32'd0, 32'h7FFFFFFF, 1'b1, 32'd0, 32'd0,
                          1'b1, 32'd0, 1'b0};
    directed_rows[5]  = '{KIND_DRAW, 32'd0, 32'h7FFFFFFF, 1'b0, 32'd0, 32'd0,
                          1'b1, 32'd0, 1'b1};
    directed_rows[6]  = '{KIND_LOAD, 32'hFFFFFFFF, 32'h00012345, 1'b1, 32'hFFFFFFFF,
                          32'hFFFFFFFF, 1'b1, 32'd0, 1'b0};
    directed_rows[7]  = '{KIND_DRAW, 32'hFFFFFFF8, 32'd8, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0};
    directed_rows[8]  = '{KIND_DRAW, 32'd3, 32'd4, 1'b0, 32'd0, 32'd0, 1'b1, 32'd3, 1'b1};
    directed_rows[9]  = '{KIND_DRAW, 32'd4, 32'd3, 1'b1, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0};
    directed_rows[10] = '{KIND_DRAW, 32'hFFFFFF9C, 32'd1000, 1'b1, 32'd0, 32'd0,
                          1'b0, 32'd0, 1'b0};
    directed_rows[11] = '{KIND_DRAW, 32'h80000000, 32'hFFFFFFFF, 1'b1, 32'd0, 32'd0,
                          1'b1, 32'h80000000, 1'b0};
    directed_rows[12] = '{KIND_DRAW, 32'hFFFFFFFE, 32'h80000000, 1'b1, 32'd0, 32'd0,
                          1'b0, 32'd0, 1'b0};
    directed_rows[13] = '{KIND_DRAW, 32'h80000000, 32'h7FFFFFFE, 1'b0, 32'd0, 32'd0,
                          1'b1, 32'h80000000, 1'b0};
    directed_rows[14] = '{KIND_LOAD, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0};
    directed_rows[15] = '{KIND_DRAW, 32'd0, 32'h40000000, 1'b0, 32'd0, 32'd0,
                          1'b1, 32'd0, 1'b1};
    directed_rows[16] = '{KIND_LOAD, 32'd0, 32'd0, 1'b0, 32'h12345678, 32'd0,
                          1'b1, 32'd0, 1'b0};
    directed_rows[17] = '{KIND_DRAW, 32'd0, 32'h40000000, 1'b0, 32'd0, 32'd0,
                          1'b0, 32'd0, 1'b0};
    directed_rows[18] = '{KIND_DRAW, 32'd7, 32'd7, 1'b1, 32'd0, 32'd0, 1'b1, 32'd7, 1'b0};
    directed_rows[19] = '{KIND_LOAD, 32'd0, 32'd0, 1'b0, 32'h80000000, 32'h6AC690C4,
                          1'b1, 32'd0, 1'b0};
    directed_rows[20] = '{KIND_DRAW, 32'h7FFFFFFF, 32'd0, 1'b0, 32'd0, 32'd0,
                          1'b0, 32'd0, 1'b0};
    directed_rows[21] = '{KIND_DRAW, 32'hFFFFFFFB, 32'd5, 1'b1, 32'd0, 32'd0,
                          1'b0, 32'd0, 1'b0};
    directed_rows[22] = '{KIND_DRAW, 32'd0, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0, 32'd0, 1'b0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        case (i / PHASE_ITEMS)
          0: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct  = 52;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 52;
          end
          default: begin
            send_idle_pct  = 37;
            recv_stall_pct = 37;
          end
        endcase
      end
      row           = '0;
      row.kind      = KIND_DRAW;
      row.bound_a   = $urandom;
      row.bound_b   = $urandom;
      row.inclusive = 1'($urandom_range(0, 1));
      row.seed_low  = $urandom;
      row.seed_high = $urandom;
      pick          = $urandom_range(0, 9);
      case (pick)
        0: row.kind = KIND_LOAD;
        1: row.bound_b = row.bound_a;
        2: ;
        3: row.bound_b = row.bound_a + (32'd1 << $urandom_range(0, 30));
        4: row.bound_b = row.bound_a + 32'h7FFFFFFF - $urandom_range(0, 2);
        default: row.bound_b = row.bound_a + $urandom_range(1, 1000);
      endcase
      if ($urandom_range(0, 1) == 1) begin
        {row.bound_a, row.bound_b} = {row.bound_b, row.bound_a};
      end
      send_item(row);
    end
    s_tvalid <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS mwc_random_in_range");
    end else begin
      $display("FAIL mwc_random_in_range");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mwc_pkg.sv
rtl/core/mwc_random_in_range.sv
rtl/core/mwc_checker.sv
verif/mwc_random_in_range_tb.sv
